// File: hw/rtl/fld_pkg.sv
// Shared types and constants for the fixed-length frame deframer.
// No dependencies; compile before the channel interfaces and the RTL.
package fld_pkg;

	localparam int unsigned TIMEOUT_W   = 16;
	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned INDEX_W     = 6;
	localparam int unsigned FRAME_CNT_W = 32;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd500;
	localparam logic [TIMEOUT_W-1:0] IDLE_MAX    = 16'hFFFF;

	localparam logic [BYTE_W-1:0] HDR0_BYTE  = 8'hAA;
	localparam logic [BYTE_W-1:0] HDR1_BYTE  = 8'hBB;
	localparam logic [BYTE_W-1:0] TAIL0_BYTE = 8'hCC;
	localparam logic [BYTE_W-1:0] TAIL1_BYTE = 8'hDD;

	// input item kinds
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// result item kinds
	localparam logic RES_PAYLOAD = 1'b0;
	localparam logic RES_STATUS  = 1'b1;

	// parser phase; the three spare codes fall back to the header search
	typedef enum logic [2:0] {
		PH_HEAD0 = 3'd0,
		PH_HEAD1 = 3'd1,
		PH_DATA  = 3'd2,
		PH_TAIL0 = 3'd3,
		PH_TAIL1 = 3'd4
	} phase_t;

	// sequencer state
	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_RD   = 2'd1,
		ST_EMIT = 2'd2
	} seq_state_t;

endpackage

// File: hw/rtl/fld_in_if.sv
// Input channel of the deframer: valid/ready plus one received word.
// Depends on fld_pkg for field widths.
interface fld_in_if;
	import fld_pkg::*;

	logic              valid;
	logic              ready;
	logic              kind;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output kind, output rx_byte, input ready);
	modport sink   (input valid, input kind, input rx_byte, output ready);

endinterface

// File: hw/rtl/fld_out_if.sv
// Output channel of the deframer: valid/ready plus one result word.
// Depends on fld_pkg for field widths.
interface fld_out_if;
	import fld_pkg::*;

	logic                   valid;
	logic                   ready;
	logic                   result_kind;
	logic [BYTE_W-1:0]      payload_byte;
	logic [INDEX_W-1:0]     payload_index;
	logic                   last_of_frame;
	logic [FRAME_CNT_W-1:0] frame_number;
	logic                   link_up;

	modport source (
		output valid, output result_kind, output payload_byte, output payload_index,
		output last_of_frame, output frame_number, output link_up, input ready
	);
	modport sink (
		input valid, input result_kind, input payload_byte, input payload_index,
		input last_of_frame, input frame_number, input link_up, output ready
	);

endinterface

// File: hw/rtl/fixed_length_frame_deframer.sv
// Fixed-length frame deframer with link watchdog: header/tail parser,
// payload buffer memory, drain sequencer and idle-tick timer.
// Depends on fld_pkg, fld_in_if and fld_out_if.
//
//   channel   dir   handshake      word
//   in_ch     in    valid/ready    kind, rx_byte
//   out_ch    out   valid/ready    result_kind .. link_up (one result)
//   cfg_wr_*  in    write enable   timeout_ms
//
// A byte or tick word is taken when the sequencer is idle and the output
// register is free or being emptied. A good tail starts a drain of the
// payload memory through its single read port: each payload byte is read,
// then loaded into the output register, with output stalls holding the
// drain and in_ch.ready low throughout. Reset puts the parser in header
// search and clears counters; the payload memory is not cleared.
module fixed_length_frame_deframer #(
	parameter int unsigned PAYLOAD_LEN = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [fld_pkg::TIMEOUT_W-1:0] cfg_wr_data,
	fld_in_if.sink                       in_ch,
	fld_out_if.source                    out_ch
);
	import fld_pkg::*;

	localparam int unsigned AW = (PAYLOAD_LEN > 1) ? $clog2(PAYLOAD_LEN) : 1;
	localparam int unsigned CW = $clog2(PAYLOAD_LEN + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(PAYLOAD_LEN - 1);
	localparam logic [CW-1:0] LEN_C    = CW'(PAYLOAD_LEN);

	logic [TIMEOUT_W-1:0]   timeout_q;
	phase_t                 phase_q, phase_d;
	logic [CW-1:0]          byte_count_q;
	logic [FRAME_CNT_W-1:0] good_frames_q;
	logic [TIMEOUT_W-1:0]   idle_ticks_q;
	logic                   seen_frame_q;
	seq_state_t             state_q, state_d;
	logic [AW-1:0]          rd_idx_q;
	logic [BYTE_W-1:0]      rd_data_q;
	logic [BYTE_W-1:0]      mem_q [PAYLOAD_LEN];

	logic                   out_valid_q;
	logic                   out_kind_q;
	logic [BYTE_W-1:0]      out_byte_q;
	logic [INDEX_W-1:0]     out_index_q;
	logic                   out_last_q;
	logic [FRAME_CNT_W-1:0] out_frame_q;
	logic                   out_up_q;

	logic                   slot_free;
	logic                   accept;
	logic                   acc_tick;
	logic                   acc_byte;
	logic                   hdr_done;
	logic                   good_tail;
	logic                   data_wr;
	logic [CW-1:0]          count_inc;
	logic [TIMEOUT_W-1:0]   idle_next;
	logic                   load_byte;

	assign slot_free = !out_valid_q || out_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE) && slot_free;
	assign accept    = in_ch.valid && in_ch.ready;
	assign acc_tick  = accept && (in_ch.kind == KIND_TICK);
	assign acc_byte  = accept && (in_ch.kind == KIND_BYTE);
	assign hdr_done  = acc_byte && (phase_q == PH_HEAD1) && (in_ch.rx_byte == HDR1_BYTE);
	assign good_tail = acc_byte && (phase_q == PH_TAIL1) && (in_ch.rx_byte == TAIL1_BYTE);
	assign data_wr   = acc_byte && (phase_q == PH_DATA);
	assign count_inc = byte_count_q + CW'(1);
	assign idle_next = (idle_ticks_q == IDLE_MAX) ? idle_ticks_q : idle_ticks_q + TIMEOUT_W'(1);

	// sequencer: next state and drain load
	always_comb begin
		state_d     = state_q;
		load_byte   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (good_tail) begin
					state_d = ST_RD;
				end
			end
			ST_RD: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (slot_free) begin
					load_byte = 1'b1;
					state_d   = (rd_idx_q == LAST_IDX) ? ST_IDLE : ST_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
		end else if (cfg_wr_en) begin
			timeout_q <= cfg_wr_data;
		end
	end

	// header/tail parser: next phase
	always_comb begin
		phase_d = phase_q;
		if (acc_byte) begin
			case (phase_q)
				PH_HEAD0: begin
					if (in_ch.rx_byte == HDR0_BYTE) begin
						phase_d = PH_HEAD1;
					end
				end
				PH_HEAD1: begin
					if (in_ch.rx_byte == HDR1_BYTE) begin
						phase_d = PH_DATA;
					end else if (in_ch.rx_byte != HDR0_BYTE) begin
						phase_d = PH_HEAD0;
					end
				end
				PH_DATA: begin
					if (count_inc >= LEN_C) begin
						phase_d = PH_TAIL0;
					end
				end
				PH_TAIL0: begin
					phase_d = (in_ch.rx_byte == TAIL0_BYTE) ? PH_TAIL1 : PH_HEAD0;
				end
				PH_TAIL1: begin
					phase_d = PH_HEAD0;
				end
				default: begin
					phase_d = PH_HEAD0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEAD0;
		end else begin
			phase_q <= phase_d;
		end
	end

	// frame bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q  <= '0;
			good_frames_q <= '0;
			idle_ticks_q  <= '0;
			seen_frame_q  <= 1'b0;
		end else if (acc_tick) begin
			idle_ticks_q <= idle_next;
		end else if (good_tail) begin
			good_frames_q <= good_frames_q + FRAME_CNT_W'(1);
			idle_ticks_q  <= '0;
			seen_frame_q  <= 1'b1;
		end else if (data_wr) begin
			byte_count_q <= count_inc;
		end else if (hdr_done) begin
			byte_count_q <= '0;
		end
	end

	// payload buffer: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (data_wr) begin
			mem_q[byte_count_q[AW-1:0]] <= in_ch.rx_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RD) begin
			rd_data_q <= mem_q[rd_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
		end else if (good_tail) begin
			rd_idx_q <= '0;
		end else if (load_byte) begin
			rd_idx_q <= rd_idx_q + AW'(1);
		end
	end

	// output register: status word on a tick, payload word during drain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc_tick || load_byte) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_tick) begin
			out_kind_q  <= RES_STATUS;
			out_byte_q  <= '0;
			out_index_q <= '0;
			out_last_q  <= 1'b1;
			out_frame_q <= good_frames_q;
			out_up_q    <= seen_frame_q && (idle_next < timeout_q);
		end else if (load_byte) begin
			out_kind_q  <= RES_PAYLOAD;
			out_byte_q  <= rd_data_q;
			out_index_q <= INDEX_W'(rd_idx_q);
			out_last_q  <= (rd_idx_q == LAST_IDX);
			out_frame_q <= good_frames_q;
			out_up_q    <= 1'b1;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.result_kind   = out_kind_q;
	assign out_ch.payload_byte  = out_byte_q;
	assign out_ch.payload_index = out_index_q;
	assign out_ch.last_of_frame = out_last_q;
	assign out_ch.frame_number  = out_frame_q;
	assign out_ch.link_up       = out_up_q;

endmodule

// File: hw/rtl/fld_checker.sv
// Port-level checks for the deframer and the bind that attaches them.
// Depends on fld_pkg and on fixed_length_frame_deframer.
module fld_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            in_kind,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic                            out_result_kind,
	input logic [fld_pkg::BYTE_W-1:0]      out_payload_byte,
	input logic [fld_pkg::INDEX_W-1:0]     out_payload_index,
	input logic                            out_last_of_frame,
	input logic [fld_pkg::FRAME_CNT_W-1:0] out_frame_number,
	input logic                            out_link_up
);
	import fld_pkg::*;

	// a taken tick shows up as a status word in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_kind == KIND_TICK)
		|=> out_valid && (out_result_kind == RES_STATUS))
		else $error("tick word did not produce a status word");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_result_kind == RES_STATUS)
		|-> (out_payload_byte == '0) && (out_payload_index == '0) && out_last_of_frame)
		else $error("status word carries payload fields");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_result_kind == RES_PAYLOAD) |-> out_link_up)
		else $error("payload word with link down");

	// input stays blocked while a frame is still draining
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_result_kind == RES_PAYLOAD) && !out_last_of_frame |-> !in_ready)
		else $error("input taken in the middle of a drain");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_frame_number)
		&& $stable(out_payload_byte))
		else $error("stalled output word changed");

endmodule

bind fixed_length_frame_deframer fld_checker u_fld_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_valid          (in_ch.valid),
	.in_ready          (in_ch.ready),
	.in_kind           (in_ch.kind),
	.out_valid         (out_ch.valid),
	.out_ready         (out_ch.ready),
	.out_result_kind   (out_ch.result_kind),
	.out_payload_byte  (out_ch.payload_byte),
	.out_payload_index (out_ch.payload_index),
	.out_last_of_frame (out_ch.last_of_frame),
	.out_frame_number  (out_ch.frame_number),
	.out_link_up       (out_ch.link_up)
);
